### design/dlr_pkg.sv
// Shared constants, result type and character classes for the number literal recognizer.
`default_nettype none
package dlr_pkg;

  localparam int unsigned MaxLenDefault = 64;
  localparam int unsigned LenW = 7;

  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LOW_E = 8'h65;
  localparam logic [7:0] CH_UP_E  = 8'h45;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    VERDICT_MORE   = 2'd0,
    VERDICT_NUMBER = 2'd1,
    VERDICT_RESCAN = 2'd2,
    VERDICT_LONG   = 2'd3
  } verdict_t;

  typedef struct packed {
    verdict_t          verdict;
    logic [LenW-1:0]   length;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_exp(input logic [7:0] c);
    is_exp = (c == CH_LOW_E) || (c == CH_UP_E);
  endfunction

  function automatic logic is_sign(input logic [7:0] c);
    is_sign = (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

endpackage
`default_nettype wire

### design/dlr_core.sv
// Recognizer state, character count and per-character verdict logic.
`default_nettype none
module dlr_core #(
  parameter int unsigned MAX_LEN = dlr_pkg::MaxLenDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            step,
  input  wire logic [7:0]      ch,
  input  wire logic            end_of_text,
  output dlr_pkg::result_t     res
);
  import dlr_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_LEN + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_LEN);

  typedef enum logic [2:0] {
    ST_START = 3'd0,
    ST_LDOT  = 3'd1,
    ST_INT   = 3'd2,
    ST_FRAC  = 3'd3,
    ST_EXP   = 3'd4,
    ST_ESIGN = 3'd5,
    ST_EDIG  = 3'd6
  } state_t;

  state_t          scan_state, scan_state_next;
  logic [CntW-1:0] read_count;
  logic            fits;
  logic            accepting;
  logic            digit;
  logic            too_long;
  logic [CntW:0]   count_inc;

  assign digit     = is_digit(ch);
  assign count_inc = {1'b0, read_count} + (CntW+1)'(1);
  assign too_long  = read_count >= MaxCnt;

  always_comb begin
    fits            = 1'b1;
    scan_state_next = ST_START;
    accepting       = 1'b0;
    unique case (scan_state)
      ST_LDOT: begin
        scan_state_next = ST_FRAC;
        fits            = digit;
      end
      ST_INT: begin
        accepting = 1'b1;
        if (digit) begin
          scan_state_next = ST_INT;
        end else if (ch == CH_DOT) begin
          scan_state_next = ST_FRAC;
        end else begin
          scan_state_next = ST_EXP;
          fits            = is_exp(ch);
        end
      end
      ST_FRAC: begin
        accepting = 1'b1;
        if (digit) begin
          scan_state_next = ST_FRAC;
        end else begin
          scan_state_next = ST_EXP;
          fits            = is_exp(ch);
        end
      end
      ST_EXP: begin
        if (digit) begin
          scan_state_next = ST_EDIG;
        end else begin
          scan_state_next = ST_ESIGN;
          fits            = is_sign(ch);
        end
      end
      ST_ESIGN: begin
        scan_state_next = ST_EDIG;
        fits            = digit;
      end
      ST_EDIG: begin
        accepting       = 1'b1;
        scan_state_next = ST_EDIG;
        fits            = digit;
      end
      default: begin
        if (digit) begin
          scan_state_next = ST_INT;
        end else begin
          scan_state_next = ST_LDOT;
          fits            = (ch == CH_DOT);
        end
      end
    endcase
    if (end_of_text) begin
      fits = 1'b0;
    end
  end

  always_comb begin
    if (fits && too_long) begin
      res.verdict = VERDICT_LONG;
      res.length  = LenW'(MaxCnt);
    end else if (fits) begin
      res.verdict = VERDICT_MORE;
      res.length  = '0;
    end else if (accepting) begin
      res.verdict = VERDICT_NUMBER;
      res.length  = LenW'(read_count);
    end else begin
      res.verdict = VERDICT_RESCAN;
      res.length  = end_of_text ? LenW'(read_count) : LenW'(count_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= ST_START;
      read_count <= '0;
    end else if (step) begin
      if (res.verdict == VERDICT_MORE) begin
        scan_state <= scan_state_next;
        read_count <= count_inc[CntW-1:0];
      end else begin
        scan_state <= ST_START;
        read_count <= '0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    read_count <= MaxCnt) else $error("character count beyond limit");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    step && (res.verdict != VERDICT_MORE) |=> (read_count == '0) && (scan_state == ST_START))
    else $error("recognizer did not restart after a verdict");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    step && (res.verdict == VERDICT_MORE) |=> read_count == $past(read_count) + 1'b1)
    else $error("count did not advance on a consumed character");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(read_count) && $stable(scan_state))
    else $error("recognizer state moved without a character");

endmodule
`default_nettype wire

### design/decimal_number_literal_recognizer.sv
// Top level: input register, recognizer core and result register for number literals.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------
//  input    | in_valid / in_stall  | ch, end_of_text
//  output   | out_valid / out_stall| verdict, length
//
// One character per cycle unless the output stalls; each gives one result via both registers.
// The rate is set by the single state update per character in the recognizer core.
// Reset clears the recognizer to the start state with a zero count and empties both registers.
// A stalled result holds the input register; the input stalls only when that register is full.
`default_nettype none
module decimal_number_literal_recognizer #(
  parameter int unsigned MAX_LEN = dlr_pkg::MaxLenDefault
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output wire logic                    in_stall,
  input  wire logic [7:0]              ch,
  input  wire logic                    end_of_text,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [1:0]                   verdict,
  output logic [dlr_pkg::LenW-1:0]     length
);
  import dlr_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_eot;
  logic       fire;
  logic       take;
  result_t    res;

  assign fire     = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !fire;
  assign take     = in_valid && !in_stall;

  dlr_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (fire),
    .ch         (s1_ch),
    .end_of_text(s1_eot),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
    if (take) begin
      s1_ch  <= ch;
      s1_eot <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (fire) begin
      verdict <= res.verdict;
      length  <= res.length;
    end
  end

endmodule
`default_nettype wire
